// ----- design/dfcr_pkg.sv -----
// Package for the downlink frame command receiver.
// Holds the shared constants, register codes, status codes and interface structs.
// No dependencies.
package dfcr_pkg;

    localparam int unsigned MAX_BODY_DEF = 32;
    localparam int unsigned COMMAND_LEN  = 15;

    localparam logic [7:0]  SYNC_BYTE = 8'hAA;
    localparam logic [11:0] YEAR_BASE = 12'd2000;

    // configuration register indexes and reset values
    localparam logic [1:0] REG_OWN_ID   = 2'd0;
    localparam logic [1:0] REG_COMPANY  = 2'd1;
    localparam logic [1:0] REG_CMD_TYPE = 2'd2;

    localparam logic [7:0]  OWN_ID_RST   = 8'd8;
    localparam logic [15:0] COMPANY_RST  = 16'hC0DE;
    localparam logic [7:0]  CMD_TYPE_RST = 8'h81;

    localparam logic [15:0] SLEEP_RST   = 16'd4;
    localparam logic [7:0]  AVERAGE_RST = 8'd5;
    localparam logic [7:0]  MEDIAN_RST  = 8'd5;

    // frame status codes
    localparam logic [2:0] ST_NONE       = 3'd0;
    localparam logic [2:0] ST_CKSUM_BAD  = 3'd1;
    localparam logic [2:0] ST_LEN_BAD    = 3'd2;
    localparam logic [2:0] ST_COMPANY    = 3'd3;
    localparam logic [2:0] ST_TYPE       = 3'd4;
    localparam logic [2:0] ST_OTHER_DEV  = 3'd5;
    localparam logic [2:0] ST_ACCEPTED   = 3'd6;

    typedef logic [COMMAND_LEN-1:0][7:0] body_t;

    typedef struct packed {
        logic [7:0]  own_id;
        logic [15:0] company;
        logic [7:0]  cmd_type;
    } cfg_t;

    // deframer events for the current transfer
    typedef struct packed {
        logic cksum_bad;
        logic frame_end;
        logic len_ok;
    } frame_evt_t;

    typedef struct packed {
        logic [7:0]  median_count;
        logic [7:0]  average_count;
        logic [15:0] sleep_interval;
        logic [7:0]  second_value;
        logic [7:0]  minute_value;
        logic [7:0]  hour_value;
        logic [7:0]  day_value;
        logic [7:0]  month_value;
        logic [11:0] year_full;
        logic        time_present;
        logic        settings_changed;
        logic [2:0]  frame_status;
    } result_t;

endpackage

// ----- design/dfcr_deframer.sv -----
// Byte deframer: sync, length, body, checksum, signal strength byte.
// Keeps the receive window flag and the first command bytes of the body.
// Depends on dfcr_pkg.
module dfcr_deframer #(
    parameter int unsigned MAX_BODY = dfcr_pkg::MAX_BODY_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic                open_window,
    input  logic [7:0]          rx_byte,
    output dfcr_pkg::frame_evt_t evt,
    output dfcr_pkg::body_t     body
);
    import dfcr_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_BODY + 1);
    localparam int unsigned IDX_W = $clog2(COMMAND_LEN);

    localparam logic [2:0] PH_SYNC  = 3'd0;
    localparam logic [2:0] PH_LEN   = 3'd1;
    localparam logic [2:0] PH_BODY  = 3'd2;
    localparam logic [2:0] PH_CKSUM = 3'd3;
    localparam logic [2:0] PH_RSSI  = 3'd4;

    logic [2:0]       phase_reg, phase_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [7:0]       sum_reg, sum_next;
    logic             done_reg, done_next;
    body_t            body_reg;
    logic [CNT_W-1:0] idx_inc;
    logic             len_bad;
    logic             body_wr;

    assign idx_inc = idx_reg + CNT_W'(1);
    assign len_bad = (rx_byte == 8'd0) || ({1'b0, rx_byte} > 9'(MAX_BODY));

    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        done_next  = done_reg;
        body_wr    = 1'b0;
        evt        = '0;
        if (open_window)
        begin
            phase_next = PH_SYNC;
            len_next   = '0;
            idx_next   = '0;
            sum_next   = '0;
            done_next  = 1'b0;
        end
        else if (!done_reg)
        begin
            unique case (phase_reg)
                PH_SYNC:
                begin
                    if (rx_byte == SYNC_BYTE)
                    begin
                        sum_next   = SYNC_BYTE;
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    idx_next = '0;
                    if (len_bad)
                    begin
                        phase_next = PH_SYNC;
                        len_next   = '0;
                        sum_next   = '0;
                    end
                    else
                    begin
                        len_next   = rx_byte[CNT_W-1:0];
                        sum_next   = sum_reg + rx_byte;
                        phase_next = PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    body_wr  = 1'b1;
                    idx_next = idx_inc;
                    sum_next = sum_reg + rx_byte;
                    if (idx_inc >= len_reg)
                        phase_next = PH_CKSUM;
                end
                PH_CKSUM:
                begin
                    if (rx_byte == sum_reg)
                        phase_next = PH_RSSI;
                    else
                    begin
                        evt.cksum_bad = 1'b1;
                        phase_next    = PH_SYNC;
                        len_next      = '0;
                        idx_next      = '0;
                        sum_next      = '0;
                    end
                end
                PH_RSSI:
                begin
                    evt.frame_end = 1'b1;
                    done_next     = 1'b1;
                    phase_next    = PH_SYNC;
                    len_next      = '0;
                    idx_next      = '0;
                    sum_next      = '0;
                end
                default:
                begin
                    phase_next = PH_SYNC;
                    len_next   = '0;
                    idx_next   = '0;
                    sum_next   = '0;
                end
            endcase
        end
        evt.len_ok = (len_reg == CNT_W'(COMMAND_LEN));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SYNC;
            len_reg   <= '0;
            idx_reg   <= '0;
            sum_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            sum_reg   <= sum_next;
            done_reg  <= done_next;
        end
    end

    // only the command bytes are kept; later body bytes feed the checksum only
    always_ff @(posedge clk)
    begin
        if (take && body_wr && (idx_reg < CNT_W'(COMMAND_LEN)))
            body_reg[idx_reg[IDX_W-1:0]] <= rx_byte;
    end

    assign body = body_reg;

endmodule

// ----- design/dfcr_cmd_check.sv -----
// Command check and stored settings for the receiver.
// Builds the result of one transfer from the deframer events and body bytes.
// Depends on dfcr_pkg.
module dfcr_cmd_check (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  dfcr_pkg::frame_evt_t evt,
    input  dfcr_pkg::body_t      body,
    input  dfcr_pkg::cfg_t       cfg,
    output dfcr_pkg::result_t    result
);
    import dfcr_pkg::*;

    logic [15:0] sleep_reg, sleep_next;
    logic [7:0]  avg_reg, avg_next;
    logic [7:0]  med_reg, med_next;
    logic        accepted;
    logic [7:0]  flags;
    logic [15:0] new_sleep;
    logic        upd_sleep;
    logic        upd_pair;
    logic        time_ok;

    assign flags     = body[4];
    assign new_sleep = {body[11], body[12]};
    assign accepted  = evt.frame_end && evt.len_ok && ({body[0], body[1]} == cfg.company)
                       && (body[2] == cfg.cmd_type) && (body[3] == cfg.own_id);
    assign time_ok   = accepted && flags[0];
    assign upd_sleep = accepted && flags[1] && (new_sleep != 16'd0) && (new_sleep != sleep_reg);
    assign upd_pair  = accepted && flags[2] && (body[13] != 8'd0) && (body[14] != 8'd0)
                       && ((body[13] != avg_reg) || (body[14] != med_reg));

    assign sleep_next = upd_sleep ? new_sleep : sleep_reg;
    assign avg_next   = upd_pair ? body[13] : avg_reg;
    assign med_next   = upd_pair ? body[14] : med_reg;

    always_comb
    begin
        result = '0;
        priority if (evt.cksum_bad)
            result.frame_status = ST_CKSUM_BAD;
        else if (!evt.frame_end)
            result.frame_status = ST_NONE;
        else if (!evt.len_ok)
            result.frame_status = ST_LEN_BAD;
        else if ({body[0], body[1]} != cfg.company)
            result.frame_status = ST_COMPANY;
        else if (body[2] != cfg.cmd_type)
            result.frame_status = ST_TYPE;
        else if (body[3] != cfg.own_id)
            result.frame_status = ST_OTHER_DEV;
        else
            result.frame_status = ST_ACCEPTED;

        result.settings_changed = upd_sleep || upd_pair;
        result.time_present     = time_ok;
        if (time_ok)
        begin
            result.year_full    = YEAR_BASE + {4'd0, body[5]};
            result.month_value  = body[6];
            result.day_value    = body[7];
            result.hour_value   = body[8];
            result.minute_value = body[9];
            result.second_value = body[10];
        end
        result.sleep_interval = sleep_next;
        result.average_count  = avg_next;
        result.median_count   = med_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sleep_reg <= SLEEP_RST;
            avg_reg   <= AVERAGE_RST;
            med_reg   <= MEDIAN_RST;
        end
        else if (take)
        begin
            sleep_reg <= sleep_next;
            avg_reg   <= avg_next;
            med_reg   <= med_next;
        end
    end

endmodule

// ----- design/downlink_frame_command_receiver_core.sv -----
// Top level of the downlink frame command receiver.
// Instantiates dfcr_deframer and dfcr_cmd_check; uses dfcr_pkg.
//
// One input transfer per clock; each produces exactly one result transfer, which
// appears in the output register on the cycle after acceptance. The whole parse and
// command check for a byte sits between the input handshake and that output register,
// so s_tready is high whenever the output register is empty or being drained. One byte
// per cycle is kept while m_tready stays high; a stalled result holds off the input
// until it is taken. Configuration writes take effect on the next clock edge.
module downlink_frame_command_receiver_core #(
    parameter int unsigned MAX_BODY = dfcr_pkg::MAX_BODY_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte
    input  logic        s_tuser,   // operation: 1 opens a new receive window
    output logic        m_tvalid,
    input  logic        m_tready,
    // frame_status[2:0], settings_changed[3], time_present[4], year_full[16:5],
    // month_value[24:17], day_value[32:25], hour_value[40:33], minute_value[48:41],
    // second_value[56:49], sleep_interval[72:57], average_count[80:73],
    // median_count[88:81], zero fill[95:89]
    output logic [95:0] m_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);
    import dfcr_pkg::*;

    cfg_t       cfg_reg;
    frame_evt_t evt;
    body_t      body;
    result_t    result;
    logic       take;
    logic       out_valid_reg;
    result_t    out_reg;

    assign s_tready = !out_valid_reg || m_tready;
    assign take     = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_id   <= OWN_ID_RST;
            cfg_reg.company  <= COMPANY_RST;
            cfg_reg.cmd_type <= CMD_TYPE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_OWN_ID:   cfg_reg.own_id   <= cfg_wdata[7:0];
                REG_COMPANY:  cfg_reg.company  <= cfg_wdata;
                REG_CMD_TYPE: cfg_reg.cmd_type <= cfg_wdata[7:0];
                default:      ;
            endcase
        end
    end

    dfcr_deframer #(
        .MAX_BODY(MAX_BODY)
    ) u_deframer (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .open_window(s_tuser),
        .rx_byte    (s_tdata),
        .evt        (evt),
        .body       (body)
    );

    dfcr_cmd_check u_cmd_check (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .evt   (evt),
        .body  (body),
        .cfg   (cfg_reg),
        .result(result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (take)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            out_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg};

endmodule
